### src/cphc_pkg.sv
// Package for the color histogram pixel classifier.
// Holds the sizing constants and the transaction structs; no dependencies.
`default_nettype none
package cphc_pkg;

	localparam int BIN_BITS   = 5;
	localparam int COUNT_BITS = 32;
	localparam int TOTAL_BITS = COUNT_BITS + 8;
	localparam int CELL_BITS  = 3 * BIN_BITS;
	localparam int CELL_COUNT = 1 << CELL_BITS;

	localparam logic ACT_TRAIN    = 1'b0;
	localparam logic ACT_CLASSIFY = 1'b1;

	typedef logic [CELL_BITS-1:0]  cell_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [TOTAL_BITS-1:0] total_t;

	typedef struct packed {
		logic       action;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       label_not_water;
	} item_t;

	typedef struct packed {
		logic is_not_water;
		logic from_prior;
	} result_t;

endpackage
`default_nettype wire

### src/cphc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Read during a write to the same address returns the old data; no dependencies.
`default_nettype none
module cphc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/cphc_bin_engine.sv
// Histogram bin engine: two bin memories, read-modify-write with forwarding,
// class totals and the classification compare. Uses cphc_pkg and cphc_ram.
`default_nettype none
module cphc_bin_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear_en,
	input  wire cphc_pkg::cell_t  clear_addr,
	input  wire logic             in_valid,
	input  wire cphc_pkg::item_t  item,
	output logic                  done,
	output cphc_pkg::result_t     result
);

	cphc_pkg::cell_t    cell_in;
	logic               valid_s1;
	logic               action_s1;
	logic               label_s1;
	cphc_pkg::cell_t    cell_s1;
	cphc_pkg::count_t   w_rdata;
	cphc_pkg::count_t   o_rdata;
	cphc_pkg::count_t   w_bin;
	cphc_pkg::count_t   o_bin;
	cphc_pkg::count_t   sel_bin;
	cphc_pkg::count_t   new_bin;
	cphc_pkg::total_t   water_total_q;
	cphc_pkg::total_t   other_total_q;
	logic               fwd_valid_q;
	logic               fwd_other_q;
	cphc_pkg::cell_t    fwd_cell_q;
	cphc_pkg::count_t   fwd_data_q;
	logic               train_s1;
	logic               w_we;
	logic               o_we;
	cphc_pkg::cell_t    waddr;
	cphc_pkg::count_t   wdata;
	logic               done_q;
	cphc_pkg::result_t  result_q;
	cphc_pkg::result_t  result_d;

	assign cell_in = {item.red[7 -: cphc_pkg::BIN_BITS],
		item.green[7 -: cphc_pkg::BIN_BITS],
		item.blue[7 -: cphc_pkg::BIN_BITS]};

	// The item one ahead writes its bin at the edge that issues this read,
	// so the RAM returns the old count; take the written value instead.
	assign w_bin = (fwd_valid_q && !fwd_other_q && fwd_cell_q == cell_s1) ? fwd_data_q : w_rdata;
	assign o_bin = (fwd_valid_q && fwd_other_q && fwd_cell_q == cell_s1) ? fwd_data_q : o_rdata;

	assign train_s1 = valid_s1 && action_s1 == cphc_pkg::ACT_TRAIN;
	assign sel_bin  = label_s1 ? o_bin : w_bin;
	assign new_bin  = (&sel_bin) ? sel_bin : sel_bin + cphc_pkg::count_t'(1);

	assign w_we  = clear_en || (train_s1 && !label_s1);
	assign o_we  = clear_en || (train_s1 && label_s1);
	assign waddr = clear_en ? clear_addr : cell_s1;
	assign wdata = clear_en ? '0 : new_bin;

	always_comb begin
		if (w_bin == '0 && o_bin == '0) begin
			result_d.from_prior   = 1'b1;
			result_d.is_not_water = water_total_q < other_total_q;
		end else begin
			result_d.from_prior   = 1'b0;
			result_d.is_not_water = w_bin < o_bin;
		end
	end

	cphc_ram #(
		.WIDTH(cphc_pkg::COUNT_BITS),
		.DEPTH(cphc_pkg::CELL_COUNT)
	) u_water_ram (
		.clk(clk),
		.we(w_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(cell_in),
		.rdata(w_rdata)
	);

	cphc_ram #(
		.WIDTH(cphc_pkg::COUNT_BITS),
		.DEPTH(cphc_pkg::CELL_COUNT)
	) u_other_ram (
		.clk(clk),
		.we(o_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(cell_in),
		.rdata(o_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			fwd_valid_q   <= 1'b0;
			done_q        <= 1'b0;
			water_total_q <= '0;
			other_total_q <= '0;
		end else begin
			valid_s1    <= in_valid;
			fwd_valid_q <= train_s1 && !clear_en;
			done_q      <= valid_s1 && action_s1 == cphc_pkg::ACT_CLASSIFY;
			if (train_s1) begin
				if (label_s1) begin
					if (!(&other_total_q)) begin
						other_total_q <= other_total_q + cphc_pkg::total_t'(1);
					end
				end else begin
					if (!(&water_total_q)) begin
						water_total_q <= water_total_q + cphc_pkg::total_t'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		action_s1   <= item.action;
		label_s1    <= item.label_not_water;
		cell_s1     <= cell_in;
		fwd_other_q <= label_s1;
		fwd_cell_q  <= cell_s1;
		fwd_data_q  <= new_bin;
		result_q    <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

### src/color_histogram_pixel_classifier_unit.sv
// Top level of the color histogram pixel classifier with the post-reset clearing sequencer.
// Uses cphc_pkg and cphc_bin_engine.
// Timing: a classify transaction passes the valid_s1 and done_q registers before done rises,
// and its result is registered alongside done. Train transactions give no result.
// Throughput: one transaction per cycle while busy is low, with forwarding of the previous bin
// write; the receiver cannot stall. After reset busy stays high while both memories are cleared.
`default_nettype none
module color_histogram_pixel_classifier_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire cphc_pkg::item_t   item,
	output logic                   done,
	output cphc_pkg::result_t      result
);

	logic            clearing_q;
	cphc_pkg::cell_t clear_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q   <= 1'b1;
			clear_addr_q <= '0;
		end else if (clearing_q) begin
			clear_addr_q <= clear_addr_q + cphc_pkg::cell_t'(1);
			if (&clear_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign busy = clearing_q;

	cphc_bin_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.clear_en(clearing_q),
		.clear_addr(clear_addr_q),
		.in_valid(start && !clearing_q),
		.item(item),
		.done(done),
		.result(result)
	);

endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for the color histogram pixel classifier: directed and random pixel
// transactions checked against an in-bench histogram predictor.
// Depends on cphc_pkg and color_histogram_pixel_classifier_unit.
`timescale 1ns / 100ps
module tb;

	localparam int RANDOM_ITEMS   = 1100;
	localparam int POOL_SIZE      = 6;
	localparam int PHASE_LEN      = 150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 200000;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	cphc_pkg::item_t   item   = '0;
	logic              busy;
	logic              done;
	cphc_pkg::result_t result;

	cphc_pkg::item_t   pixel_queue[$];
	cphc_pkg::result_t verdict_queue[$];

	cphc_pkg::count_t  water_hist [cphc_pkg::CELL_COUNT];
	cphc_pkg::count_t  other_hist [cphc_pkg::CELL_COUNT];
	cphc_pkg::total_t  water_count;
	cphc_pkg::total_t  other_count;

	int      sent_count  = 0;
	int      errors      = 0;
	int      idle_cycles = 0;

	color_histogram_pixel_classifier_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic cphc_pkg::item_t make_pixel(logic act, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic lbl);
		cphc_pkg::item_t p;
		p.action          = act;
		p.red             = r;
		p.green           = g;
		p.blue            = b;
		p.label_not_water = lbl;
		return p;
	endfunction

	task automatic queue_pixel(cphc_pkg::item_t p);
		pixel_queue.insert(pixel_queue.size(), p);
	endtask

	function automatic cphc_pkg::cell_t cell_index(cphc_pkg::item_t p);
		return {p.red[7 -: cphc_pkg::BIN_BITS], p.green[7 -: cphc_pkg::BIN_BITS],
			p.blue[7 -: cphc_pkg::BIN_BITS]};
	endfunction

	// Updates the histograms for a training pixel, or predicts the verdict for
	// a classify pixel. Returns 1 when a verdict is produced.
	function automatic bit apply_pixel(cphc_pkg::item_t p, output cphc_pkg::result_t verdict);
		cphc_pkg::cell_t  c;
		cphc_pkg::count_t wb;
		cphc_pkg::count_t ob;
		c       = cell_index(p);
		verdict = '0;
		if (p.action == cphc_pkg::ACT_TRAIN) begin
			if (p.label_not_water) begin
				if (other_hist[c] != '1) other_hist[c] = other_hist[c] + cphc_pkg::count_t'(1);
				if (other_count != '1) other_count = other_count + cphc_pkg::total_t'(1);
			end else begin
				if (water_hist[c] != '1) water_hist[c] = water_hist[c] + cphc_pkg::count_t'(1);
				if (water_count != '1) water_count = water_count + cphc_pkg::total_t'(1);
			end
			return 1'b0;
		end
		wb = water_hist[c];
		ob = other_hist[c];
		if (wb == '0 && ob == '0) begin
			verdict.from_prior   = 1'b1;
			verdict.is_not_water = (water_count < other_count);
		end else begin
			verdict.from_prior   = 1'b0;
			verdict.is_not_water = (wb < ob);
		end
		return 1'b1;
	endfunction

	function automatic bit sender_idles(int accepted);
		case ((accepted / PHASE_LEN) % 3)
			1: return ($urandom_range(0, 99) < 85);
			2: return ($urandom_range(0, 99) < 16);
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cphc_pkg::result_t verdict;
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else begin
			if (start && !busy) begin
				if (apply_pixel(item, verdict)) verdict_queue.insert(verdict_queue.size(), verdict);
				sent_count = sent_count + 1;
			end
			if (!start || !busy) begin
				if (pixel_queue.size() != 0 && !sender_idles(sent_count)) begin
					start <= 1'b1;
					item  <= pixel_queue.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cphc_pkg::result_t want;
		if (arst_n && done) begin
			if (verdict_queue.size() == 0) begin
				$error("result with no classify transaction waiting: %b", result);
				errors = errors + 1;
			end else begin
				want = verdict_queue.pop_front();
				if (result.is_not_water !== want.is_not_water) begin
					$error("is_not_water: expected %0b, actual %0b",
						want.is_not_water, result.is_not_water);
					errors = errors + 1;
				end
				if (result.from_prior !== want.from_prior) begin
					$error("from_prior: expected %0b, actual %0b",
						want.from_prior, result.from_prior);
					errors = errors + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		cphc_pkg::cell_t pool [POOL_SIZE];
		int              bias [POOL_SIZE];
		int              k;
		int              slot;
		cphc_pkg::cell_t c;
		logic            act;
		logic [7:0]      r;
		logic [7:0]      g;
		logic [7:0]      b;

		for (k = 0; k < cphc_pkg::CELL_COUNT; k++) begin
			water_hist[k] = '0;
			other_hist[k] = '0;
		end
		water_count = '0;
		other_count = '0;

		// Untrained block, then equal and unequal bins and totals.
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h00, 8'h00, 8'h00, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'hff, 8'hff, 8'hff, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'h00, 8'h00, 8'h00, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h07, 8'h07, 8'h07, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h80, 8'h40, 8'h20, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'hff, 8'hff, 8'hff, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'hf8, 8'hf9, 8'hfa, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'hf8, 8'hf8, 8'hf8, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h80, 8'h40, 8'h20, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'h01, 8'h02, 8'h03, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h12, 8'h34, 8'h56, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'h00, 8'h00, 8'h00, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h00, 8'h00, 8'h00, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'h05, 8'h06, 8'h07, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h00, 8'h00, 8'h07, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'h00, 8'hff, 8'h00, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h07, 8'hf8, 8'h07, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'h08, 8'h00, 8'h00, 1'b1));
		queue_pixel(make_pixel(cphc_pkg::ACT_TRAIN,    8'haa, 8'h55, 8'hcc, 1'b0));
		queue_pixel(make_pixel(cphc_pkg::ACT_CLASSIFY, 8'hab, 8'h57, 8'hcf, 1'b1));

		// Random part: mostly a few hot cells so bins build up, some noise.
		pool[0] = '0;
		pool[1] = '1;
		for (k = 2; k < POOL_SIZE; k++) pool[k] = cphc_pkg::cell_t'($urandom());
		for (k = 0; k < POOL_SIZE; k++) bias[k] = $urandom_range(5, 95);
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			act = ($urandom_range(0, 99) < 45) ? cphc_pkg::ACT_CLASSIFY : cphc_pkg::ACT_TRAIN;
			if ($urandom_range(0, 99) < 75) begin
				slot = $urandom_range(0, POOL_SIZE - 1);
				c    = pool[slot];
				r    = (8'(c[3*cphc_pkg::BIN_BITS-1 -: cphc_pkg::BIN_BITS])
						<< (8 - cphc_pkg::BIN_BITS))
					| 8'($urandom_range(0, (1 << (8 - cphc_pkg::BIN_BITS)) - 1));
				g    = (8'(c[2*cphc_pkg::BIN_BITS-1 -: cphc_pkg::BIN_BITS])
						<< (8 - cphc_pkg::BIN_BITS))
					| 8'($urandom_range(0, (1 << (8 - cphc_pkg::BIN_BITS)) - 1));
				b    = (8'(c[cphc_pkg::BIN_BITS-1 -: cphc_pkg::BIN_BITS])
						<< (8 - cphc_pkg::BIN_BITS))
					| 8'($urandom_range(0, (1 << (8 - cphc_pkg::BIN_BITS)) - 1));
				queue_pixel(make_pixel(act, r, g, b,
					$urandom_range(0, 99) < bias[slot]));
			end else begin
				queue_pixel(make_pixel(act, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1))));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_queue.size() != 0 || start) @(negedge clk);
		while (verdict_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### color_histogram_pixel_classifier_unit.f
src/cphc_pkg.sv
src/cphc_ram.sv
src/cphc_bin_engine.sv
src/color_histogram_pixel_classifier_unit.sv
verif/tb.sv
